/* src/keyed_light_slot_table_top_defines.svh */
// Assertion macros shared by the light slot table RTL.
`ifndef KEYED_LIGHT_SLOT_TABLE_TOP_DEFINES_SVH
`define KEYED_LIGHT_SLOT_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define KLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define KLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kls_pkg.sv */
// Types and codes for the keyed light slot table.
package kls_pkg;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_DECAY = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        HOW_KEY     = 2'd0,
        HOW_EXPIRED = 2'd1,
        HOW_FORCED  = 2'd2,
        HOW_NONE    = 2'd3
    } how_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDWAIT,
        ST_WRITE,
        ST_FINISH
    } state_t;

    localparam int unsigned DECAY_SHIFT = 10;

    typedef struct packed {
        func_t       func;
        logic [15:0] light_key;
        logic [31:0] now_time;
        logic [15:0] elapsed_time;
        logic [15:0] new_radius;
        logic [31:0] new_expiry;
        logic [15:0] new_decay;
        logic [4:0]  slot_select;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  slot_index;
        how_t        found_how;
        logic [15:0] out_key;
        logic [15:0] out_radius;
        logic [31:0] out_expiry;
        logic        out_live;
    } out_word_t;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] radius;
        logic [31:0] expiry;
        logic [15:0] decay;
    } slot_t;

endpackage

/* src/keyed_light_slot_table_top.sv */
// Allocate scans every slot then writes one; decay rewrites live slots during its scan.
// One item at a time: allocate and decay walk the slot memory one entry per cycle through
// its single read port, and the next word is taken only once a result is loaded for output.
// A finished result sits in the output register while the next word is accepted.
// Reset (aresetn, synchronous, active low) clears control and the per-slot valid bits;
// an unwritten slot reads as all zero, so no clearing pass is needed.
`include "keyed_light_slot_table_top_defines.svh"

module keyed_light_slot_table_top
    import kls_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

    state_t              state_reg, state_next;
    in_word_t            word_reg, word_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                pipe_vld_reg;
    logic [IDX_W-1:0]    pipe_idx_reg;
    logic                km_found_reg, km_found_next;
    logic [IDX_W-1:0]    km_idx_reg, km_idx_next;
    logic                ex_found_reg, ex_found_next;
    logic [IDX_W-1:0]    ex_idx_reg, ex_idx_next;
    out_word_t           res_reg, res_next;
    out_word_t           m_word_reg;
    logic                m_valid_reg, m_valid_next;
    logic                out_load;

    // slot memory and per-slot valid bits
    slot_t                 mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    slot_t                 mem_q;
    logic                  rd_vld_reg;
    logic                  rd_en, wr_en;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    slot_t                 wr_data;

    slot_t                 ent;
    logic [31:0]           prod;
    logic [21:0]           loss;
    logic                  s_fire;
    logic                  last_ent;
    logic [IDX_W-1:0]      pick_idx;
    how_t                  pick_how;

    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;
    assign ent      = rd_vld_reg ? mem_q : '0;
    assign prod     = word_reg.elapsed_time * ent.decay;
    assign loss     = prod[31:DECAY_SHIFT];
    assign last_ent = (pipe_idx_reg == IDX_W'(SLOT_COUNT - 1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            pipe_vld_reg <= rd_en && (state_reg == ST_SCAN);
        end
    end

    always_ff @(posedge aclk) begin
        pipe_idx_reg <= rd_addr;
        word_reg     <= word_next;
        rd_cnt_reg   <= rd_cnt_next;
        km_idx_reg   <= km_idx_next;
        ex_idx_reg   <= ex_idx_next;
        res_reg      <= res_next;
        if (out_load) begin
            m_word_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            km_found_reg <= 1'b0;
            ex_found_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            km_found_reg <= km_found_next;
            ex_found_reg <= ex_found_next;
        end
    end

    // allocate choice: key match, else first expired, else slot 0
    always_comb begin
        if (km_found_reg) begin
            pick_idx = km_idx_reg;
            pick_how = HOW_KEY;
        end else if (ex_found_reg) begin
            pick_idx = ex_idx_reg;
            pick_how = HOW_EXPIRED;
        end else begin
            pick_idx = '0;
            pick_how = HOW_FORCED;
        end
    end

    always_comb begin
        state_next    = state_reg;
        word_next     = word_reg;
        rd_cnt_next   = rd_cnt_reg;
        km_found_next = km_found_reg;
        km_idx_next   = km_idx_reg;
        ex_found_next = ex_found_reg;
        ex_idx_next   = ex_idx_reg;
        res_next      = res_reg;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = rd_cnt_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = pipe_idx_reg;
        wr_data       = ent;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    word_next     = s_word;
                    rd_cnt_next   = '0;
                    km_found_next = 1'b0;
                    ex_found_next = 1'b0;
                    res_next      = '0;
                    res_next.found_how = HOW_NONE;
                    case (s_word.func)
                        FUNC_ALLOC, FUNC_DECAY: begin
                            state_next = ST_SCAN;
                        end
                        FUNC_READ: begin
                            if (9'(s_word.slot_select) < 9'(SLOT_COUNT)) begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(s_word.slot_select);
                                state_next = ST_RDWAIT;
                            end else begin
                                res_next.slot_index = s_word.slot_select;
                                state_next          = ST_FINISH;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (rd_cnt_reg < CNT_W'(SLOT_COUNT)) begin
                    rd_en       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (pipe_vld_reg) begin
                    if (word_reg.func == FUNC_ALLOC) begin
                        if (!km_found_reg && word_reg.light_key != '0
                                && ent.key == word_reg.light_key) begin
                            km_found_next = 1'b1;
                            km_idx_next   = pipe_idx_reg;
                        end
                        if (!ex_found_reg && ent.expiry < word_reg.now_time) begin
                            ex_found_next = 1'b1;
                            ex_idx_next   = pipe_idx_reg;
                        end
                        if (last_ent) begin
                            state_next = ST_WRITE;
                        end
                    end else begin
                        // decay: live slots with radius lose elapsed*decay/1024
                        if (ent.expiry >= word_reg.now_time && ent.radius != '0) begin
                            wr_en = 1'b1;
                            if (loss >= 22'(ent.radius)) begin
                                wr_data.radius = '0;
                            end else begin
                                wr_data.radius = ent.radius - loss[15:0];
                            end
                        end
                        if (last_ent) begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_RDWAIT: begin
                res_next.slot_index = word_reg.slot_select;
                res_next.found_how  = HOW_NONE;
                res_next.out_key    = ent.key;
                res_next.out_radius = ent.radius;
                res_next.out_expiry = ent.expiry;
                res_next.out_live   = (ent.expiry >= word_reg.now_time);
                state_next          = ST_FINISH;
            end

            ST_WRITE: begin
                wr_en          = 1'b1;
                wr_addr        = pick_idx;
                wr_data.key    = word_reg.light_key;
                wr_data.radius = word_reg.new_radius;
                wr_data.expiry = word_reg.new_expiry;
                wr_data.decay  = word_reg.new_decay;
                res_next.slot_index = 5'(pick_idx);
                res_next.found_how  = pick_how;
                res_next.out_key    = word_reg.light_key;
                res_next.out_radius = word_reg.new_radius;
                res_next.out_expiry = word_reg.new_expiry;
                res_next.out_live   = (word_reg.new_expiry >= word_reg.now_time);
                state_next          = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    `KLS_ASSERT_NEXT(a_one_item, s_fire, !s_ready, "second word accepted while busy")
    `KLS_ASSERT_NOW(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr,
        "slot read and written in the same cycle")
    `KLS_ASSERT_NEXT(a_scan_feed, pipe_vld_reg && !last_ent && state_reg == ST_SCAN,
        pipe_vld_reg, "scan data stream broke before the last slot")
    `KLS_ASSERT_NEXT(a_out_hold, m_valid_reg && !m_ready, m_valid_reg && $stable(m_word_reg),
        "pending result changed before it was taken")

endmodule
